@@ rtl/lffe_pkg.sv @@
// Package for the level fade/flicker engine.
// Item types, request and mode codes, controller/datapath command structs, LFSR step.
// No dependencies.
`default_nettype none

package lffe_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LEVEL_DEF     = 255;
    localparam int DEFAULT_LEVEL_DEF = 0;
    localparam int FLICK_MIN_MS_DEF  = 10;

    // Fixed by the item format
    localparam int MIN_LEVEL   = 0;
    localparam int TIME_W      = 24;
    localparam int LFSR_W      = 16;
    localparam int OUT_LEVEL_W = 8;

    localparam logic [TIME_W-1:0] ELAPSED_MAX = '1;
    localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS   = 16'hB400;

    // Request codes
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_SET        = 3'd1;
    localparam logic [2:0] REQ_FADE_CUR   = 3'd2;
    localparam logic [2:0] REQ_FADE_START = 3'd3;
    localparam logic [2:0] REQ_FLICKER    = 3'd4;

    // Mode codes
    localparam logic [1:0] MODE_CONST   = 2'd0;
    localparam logic [1:0] MODE_FADE    = 2'd1;
    localparam logic [1:0] MODE_FLICKER = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] level;
        logic signed [15:0] start_level;
        logic [TIME_W-1:0]  fade_len;
        logic [TIME_W-1:0]  flick_limit;
    } req_item_t;

    typedef struct packed {
        logic [OUT_LEVEL_W-1:0] cur_level;
        logic [1:0]             mode;
    } rsp_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic apply;
        logic len_load;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic ramp_mode;
        logic restart;
    } dp_status_t;

    // Galois LFSR, right shift
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] r;
        r = s >> 1;
        if (s[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lffe_dp.sv @@
// Datapath of the level fade/flicker engine: level/ramp state, multiplier,
// shared radix-2 divider and result register. Uses lffe_pkg; driven by lffe_ctrl.
`default_nettype none

module lffe_dp #(
    parameter int MAX_LEVEL     = lffe_pkg::MAX_LEVEL_DEF,
    parameter int DEFAULT_LEVEL = lffe_pkg::DEFAULT_LEVEL_DEF,
    parameter int FLICK_MIN_MS  = lffe_pkg::FLICK_MIN_MS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lffe_pkg::req_item_t  req,
    input  wire lffe_pkg::dp_cmd_t    cmd,
    output lffe_pkg::dp_status_t      status,
    output lffe_pkg::rsp_item_t       rsp
);

    localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
    localparam int TIME_W = lffe_pkg::TIME_W;
    localparam int PROD_W = TIME_W + LVL_W;
    localparam int VAL_W  = LVL_W + 2;
    localparam logic [TIME_W-1:0] FlickMin = TIME_W'(FLICK_MIN_MS);
    localparam logic [LVL_W-1:0]  MinLvl   = LVL_W'(lffe_pkg::MIN_LEVEL);

    function automatic logic [LVL_W-1:0] clamp_level(input logic signed [15:0] v);
        logic [LVL_W-1:0] r;
        if (v < 16'sd0)
        begin
            r = MinLvl;
        end
        else if (int'(v) > MAX_LEVEL)
        begin
            r = LVL_W'(MAX_LEVEL);
        end
        else
        begin
            r = LVL_W'($unsigned(v));
        end
        return r;
    endfunction

    // Ramp and level state
    logic [LVL_W-1:0]            level_reg, level_next;
    logic [1:0]                  mode_reg, mode_next;
    logic [TIME_W-1:0]           elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]           ramp_len_reg, ramp_len_next;
    logic [LVL_W-1:0]            ramp_start_reg, ramp_start_next;
    logic [LVL_W-1:0]            ramp_target_reg, ramp_target_next;
    logic [TIME_W-1:0]           bound_reg, bound_next;
    logic [lffe_pkg::LFSR_W-1:0] lfsr_reg, lfsr_next;

    // Divider
    logic [PROD_W-1:0] num_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] den_reg;
    logic              neg_reg;
    lffe_pkg::rsp_item_t rsp_reg;

    logic [LVL_W-1:0]            lvl_clamped;
    logic [LVL_W-1:0]            start_clamped;
    logic                        active;
    logic signed [LVL_W:0]       diff;
    logic [LVL_W:0]              neg_diff;
    logic [LVL_W-1:0]            diff_mag;
    logic [PROD_W-1:0]           prod;
    logic [TIME_W:0]             trial_rem;
    logic [TIME_W:0]             trial_diff;
    logic                        q_bit;
    logic signed [VAL_W-1:0]     start_s;
    logic signed [VAL_W-1:0]     target_s;
    logic signed [VAL_W-1:0]     q_s;
    logic signed [VAL_W-1:0]     ramp_val;
    logic signed [VAL_W-1:0]     flick_val;
    logic [LVL_W-1:0]            apply_level;
    logic [1:0]                  apply_mode;
    logic [lffe_pkg::LFSR_W-1:0] lfsr_new;
    logic                        draw_load;
    logic [TIME_W-1:0]           span;

    assign lvl_clamped   = clamp_level(req.level);
    assign start_clamped = clamp_level(req.start_level);
    assign active        = elapsed_reg < ramp_len_reg;

    assign diff     = $signed({1'b0, ramp_target_reg}) - $signed({1'b0, ramp_start_reg});
    assign neg_diff = -diff;
    assign diff_mag = diff[LVL_W] ? neg_diff[LVL_W-1:0] : diff[LVL_W-1:0];
    assign prod     = PROD_W'(elapsed_reg) * PROD_W'(diff_mag);

    // One quotient bit per step; a remainder below the divisor never borrows
    assign trial_rem  = {rem_reg, num_reg[PROD_W-1]};
    assign trial_diff = trial_rem - {1'b0, den_reg};
    assign q_bit      = !trial_diff[TIME_W];

    // Quotient magnitude is below |target - start|, so LVL_W bits hold it
    assign start_s  = $signed({2'b00, ramp_start_reg});
    assign target_s = $signed({2'b00, ramp_target_reg});
    assign q_s      = $signed({2'b00, num_reg[LVL_W-1:0]});

    always_comb
    begin
        if (!active)
        begin
            ramp_val = target_s;
        end
        else if (neg_reg)
        begin
            ramp_val = start_s - q_s;
        end
        else
        begin
            ramp_val = start_s + q_s;
        end

        flick_val = ramp_val;
        if (flick_val < start_s)
        begin
            flick_val = start_s;
        end
        if (flick_val > target_s)
        begin
            flick_val = target_s;
        end

        if (mode_reg == lffe_pkg::MODE_FLICKER)
        begin
            apply_level = flick_val[LVL_W-1:0];
            apply_mode  = mode_reg;
        end
        else if (mode_reg == lffe_pkg::MODE_FADE && !active)
        begin
            apply_level = ramp_target_reg;
            apply_mode  = lffe_pkg::MODE_CONST;
        end
        else
        begin
            apply_level = ramp_val[LVL_W-1:0];
            apply_mode  = mode_reg;
        end
    end

    assign status.ramp_mode = (mode_reg != lffe_pkg::MODE_CONST);
    assign status.restart   = (mode_reg == lffe_pkg::MODE_FLICKER) && !active;

    assign lfsr_new  = lffe_pkg::lfsr_step(lfsr_reg);
    assign draw_load = (cmd.accept && req.req_type == lffe_pkg::REQ_FLICKER) ||
                       (cmd.apply && status.restart);
    assign span      = (cmd.accept ? req.flick_limit : bound_reg) - FlickMin;

    always_comb
    begin
        level_next       = level_reg;
        mode_next        = mode_reg;
        elapsed_next     = elapsed_reg;
        ramp_len_next    = ramp_len_reg;
        ramp_start_next  = ramp_start_reg;
        ramp_target_next = ramp_target_reg;
        bound_next       = bound_reg;
        lfsr_next        = lfsr_reg;

        if (cmd.accept)
        begin
            unique case (req.req_type)
                lffe_pkg::REQ_TICK:
                begin
                    if (elapsed_reg != lffe_pkg::ELAPSED_MAX)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                lffe_pkg::REQ_SET:
                begin
                    level_next = lvl_clamped;
                end
                lffe_pkg::REQ_FADE_CUR, lffe_pkg::REQ_FADE_START:
                begin
                    elapsed_next     = '0;
                    ramp_len_next    = req.fade_len;
                    ramp_start_next  = (req.req_type == lffe_pkg::REQ_FADE_CUR) ?
                                       level_reg : start_clamped;
                    ramp_target_next = lvl_clamped;
                    mode_next        = lffe_pkg::MODE_FADE;
                end
                lffe_pkg::REQ_FLICKER:
                begin
                    bound_next       = req.flick_limit;
                    mode_next        = lffe_pkg::MODE_FLICKER;
                    elapsed_next     = '0;
                    ramp_start_next  = MinLvl;
                    ramp_target_next = level_reg;
                    lfsr_next        = lfsr_new;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.apply)
        begin
            level_next = apply_level;
            mode_next  = apply_mode;
            if (status.restart)
            begin
                elapsed_next     = '0;
                ramp_start_next  = MinLvl;
                ramp_target_next = apply_level;
                lfsr_next        = lfsr_new;
            end
        end

        if (cmd.len_load)
        begin
            ramp_len_next = (bound_reg <= FlickMin) ? FlickMin : FlickMin + rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= LVL_W'(DEFAULT_LEVEL);
            mode_reg        <= lffe_pkg::MODE_CONST;
            elapsed_reg     <= '0;
            ramp_len_reg    <= '0;
            ramp_start_reg  <= '0;
            ramp_target_reg <= '0;
            bound_reg       <= '0;
            lfsr_reg        <= lffe_pkg::LFSR_SEED;
        end
        else
        begin
            level_reg       <= level_next;
            mode_reg        <= mode_next;
            elapsed_reg     <= elapsed_next;
            ramp_len_reg    <= ramp_len_next;
            ramp_start_reg  <= ramp_start_next;
            ramp_target_reg <= ramp_target_next;
            bound_reg       <= bound_next;
            lfsr_reg        <= lfsr_next;
        end
    end

    // Divider operands and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            num_reg <= prod;
            rem_reg <= '0;
            den_reg <= ramp_len_reg;
            neg_reg <= diff[LVL_W];
        end
        else if (draw_load)
        begin
            num_reg <= PROD_W'(lfsr_new);
            rem_reg <= '0;
            den_reg <= span;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[PROD_W-2:0], q_bit};
            rem_reg <= q_bit ? trial_diff[TIME_W-1:0] : trial_rem[TIME_W-1:0];
        end

        if (cmd.out_load)
        begin
            rsp_reg.cur_level <= lffe_pkg::OUT_LEVEL_W'(level_reg);
            rsp_reg.mode      <= mode_reg;
        end
    end

    assign rsp = rsp_reg;

    a_flick_start_min: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == lffe_pkg::MODE_FLICKER |-> ramp_start_reg == MinLvl)
        else $error("flicker ramp does not start at the minimum level");

    a_flick_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.len_load |=> ramp_len_reg >= FlickMin)
        else $error("drawn flicker ramp shorter than the minimum");

endmodule

`default_nettype wire

@@ rtl/lffe_ctrl.sv @@
// Controller of the level fade/flicker engine: sequences accept, multiply,
// divide, apply, draw and result hand-off. Uses lffe_pkg; drives lffe_dp.
`default_nettype none

module lffe_ctrl #(
    parameter int PROD_W = lffe_pkg::TIME_W + 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic [2:0]           req_type,
    input  wire logic                 rsp_stall,
    input  wire lffe_pkg::dp_status_t status,
    output logic                      req_stall,
    output logic                      rsp_valid,
    output lffe_pkg::dp_cmd_t         cmd
);

    localparam int CNT_W = $clog2(PROD_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mod_op_reg, mod_op_next;
    logic             rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mod_op_next    = mod_op_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    priority if (req_type == lffe_pkg::REQ_TICK && status.ramp_mode)
                    begin
                        state_next = S_MUL;
                    end
                    else if (req_type == lffe_pkg::REQ_FLICKER)
                    begin
                        // draw of the first flicker ramp length
                        state_next  = S_DIV;
                        cnt_next    = CNT_W'(PROD_W - 1);
                        mod_op_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_DIV;
                cnt_next     = CNT_W'(PROD_W - 1);
                mod_op_next  = 1'b0;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = mod_op_reg ? S_LEN : S_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (status.restart)
                begin
                    state_next  = S_DIV;
                    cnt_next    = CNT_W'(PROD_W - 1);
                    mod_op_next = 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_LEN:
            begin
                cmd.len_load = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            mod_op_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mod_op_reg    <= mod_op_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_APPLY || state_reg == S_LEN))
        else $error("divider did not hand off after its last step");

    a_apply_after_quot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> ($past(state_reg) == S_DIV && !$past(mod_op_reg)))
        else $error("ramp value applied without a finished quotient");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && req_type == lffe_pkg::REQ_TICK && !status.ramp_mode) |=> state_reg == S_FIN)
        else $error("tick in constant mode did not go straight to result");

endmodule

`default_nettype wire

@@ rtl/level_fade_flicker_engine_core.sv @@
// Level fade/flicker engine, top level. Instantiates lffe_ctrl and lffe_dp;
// uses lffe_pkg for item types and codes.
//
// One result per accepted item: the level and mode after the item is applied.
// Set, fade, unused codes and ticks in constant mode go from accept straight to
// the result. A tick while fading or flickering runs through the multiplier and
// the radix-2 divider (PROD_W = 24 + clog2(MAX_LEVEL+1), 32 at the default),
// which forms elapsed*(target-start)/duration one bit per cycle. A tick that ends
// a flicker ramp draws the next ramp length through the same divider (LFSR modulo
// the interval span); a flicker request does the draw alone. One item is in work
// at a time; the next is taken as soon as the result sits in the output register,
// even if it is stalled.
`default_nettype none

module level_fade_flicker_engine_core #(
    parameter int MAX_LEVEL     = lffe_pkg::MAX_LEVEL_DEF,
    parameter int DEFAULT_LEVEL = lffe_pkg::DEFAULT_LEVEL_DEF,
    parameter int FLICK_MIN_MS  = lffe_pkg::FLICK_MIN_MS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire lffe_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output lffe_pkg::rsp_item_t      rsp
);

    localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
    localparam int PROD_W = lffe_pkg::TIME_W + LVL_W;

    lffe_pkg::dp_cmd_t    cmd;
    lffe_pkg::dp_status_t status;

    lffe_ctrl #(
        .PROD_W (PROD_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .rsp_stall (rsp_stall),
        .status    (status),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .cmd       (cmd)
    );

    lffe_dp #(
        .MAX_LEVEL     (MAX_LEVEL),
        .DEFAULT_LEVEL (DEFAULT_LEVEL),
        .FLICK_MIN_MS  (FLICK_MIN_MS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for level_fade_flicker_engine_core: directed table, then random command/tick streams.
// Each item is checked against a fixed table result or an in-bench level/fade/flicker model.
// Depends on rtl/lffe_pkg.sv and the core RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXL      = lffe_pkg::MAX_LEVEL_DEF;
    localparam int DEFL      = lffe_pkg::DEFAULT_LEVEL_DEF;
    localparam int FLICK_MIN = lffe_pkg::FLICK_MIN_MS_DEF;
    localparam int ITEMS     = 1100;

    // request codes the block ignores
    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    lffe_pkg::req_item_t req;
    logic                rsp_valid;
    logic                rsp_stall;
    lffe_pkg::rsp_item_t rsp;

    level_fade_flicker_engine_core #(
        .MAX_LEVEL     (MAXL),
        .DEFAULT_LEVEL (DEFL),
        .FLICK_MIN_MS  (FLICK_MIN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model state
    int          lvl_q;
    logic [1:0]  mode_q;
    int unsigned elapsed_q;
    int unsigned len_q;
    int          rstart_q;
    int          rtarget_q;
    int unsigned bound_q;
    logic [15:0] lfsr_q;

    lffe_pkg::rsp_item_t level_due[$];
    bit        calm;
    int        err_count;
    int        sent_count;
    int        checked_count;
    int        tick_count;
    int        fade_count;
    int        flick_count;
    int        restart_count;

    typedef struct {
        lffe_pkg::req_item_t item;
        int                  reps;
        bit                  fixed;
        lffe_pkg::rsp_item_t want;
    } row_t;

    row_t plan[$];

    function automatic int clamp_lvl(longint v);
        if (v < lffe_pkg::MIN_LEVEL)
        begin
            return lffe_pkg::MIN_LEVEL;
        end
        if (v > MAXL)
        begin
            return MAXL;
        end
        return int'(v);
    endfunction

    function automatic longint ramp_now();
        longint diff;
        if (len_q == 0 || elapsed_q >= len_q)
        begin
            return rtarget_q;
        end
        diff = longint'(rtarget_q) - longint'(rstart_q);
        return longint'(rstart_q) + (longint'(elapsed_q) * diff) / longint'(len_q);
    endfunction

    // one LFSR step per draw, then length in [FLICK_MIN, bound), or FLICK_MIN if bound <= FLICK_MIN
    function automatic int unsigned draw_ramp_len();
        logic        lsb;
        int unsigned span;
        lsb    = lfsr_q[0];
        lfsr_q = lfsr_q >> 1;
        if (lsb)
        begin
            lfsr_q = lfsr_q ^ lffe_pkg::LFSR_TAPS;
        end
        if (bound_q <= FLICK_MIN)
        begin
            return FLICK_MIN;
        end
        span = bound_q - FLICK_MIN;
        return (FLICK_MIN + int'(lfsr_q) % span) & 32'hFFFFFF;
    endfunction

    function automatic void begin_flicker_ramp();
        elapsed_q = 0;
        len_q     = draw_ramp_len();
        rstart_q  = lffe_pkg::MIN_LEVEL;
        rtarget_q = lvl_q;
    endfunction

    function automatic lffe_pkg::rsp_item_t lamp_step(lffe_pkg::req_item_t it);
        lffe_pkg::rsp_item_t r;
        longint              v;
        case (it.req_type)
            lffe_pkg::REQ_TICK:
            begin
                if (elapsed_q < lffe_pkg::ELAPSED_MAX)
                begin
                    elapsed_q++;
                end
                if (mode_q == lffe_pkg::MODE_FADE)
                begin
                    if (elapsed_q >= len_q)
                    begin
                        lvl_q  = rtarget_q;
                        mode_q = lffe_pkg::MODE_CONST;
                    end
                    else
                    begin
                        lvl_q = clamp_lvl(ramp_now());
                    end
                end
                else if (mode_q == lffe_pkg::MODE_FLICKER)
                begin
                    v = ramp_now();
                    if (v < rstart_q)
                    begin
                        v = rstart_q;
                    end
                    if (v > rtarget_q)
                    begin
                        v = rtarget_q;
                    end
                    lvl_q = clamp_lvl(v);
                    if (elapsed_q >= len_q)
                    begin
                        restart_count++;
                        begin_flicker_ramp();
                    end
                end
            end
            lffe_pkg::REQ_SET:
            begin
                lvl_q = clamp_lvl(longint'(it.level));
            end
            lffe_pkg::REQ_FADE_CUR, lffe_pkg::REQ_FADE_START:
            begin
                elapsed_q = 0;
                len_q     = it.fade_len;
                rstart_q  = (it.req_type == lffe_pkg::REQ_FADE_CUR) ?
                            lvl_q : clamp_lvl(longint'(it.start_level));
                rtarget_q = clamp_lvl(longint'(it.level));
                mode_q    = lffe_pkg::MODE_FADE;
            end
            lffe_pkg::REQ_FLICKER:
            begin
                bound_q = it.flick_limit;
                mode_q  = lffe_pkg::MODE_FLICKER;
                begin_flicker_ramp();
            end
            default:
            begin
            end
        endcase
        r.cur_level = 8'(lvl_q);
        r.mode      = mode_q;
        return r;
    endfunction

    function automatic lffe_pkg::req_item_t noise_item();
        lffe_pkg::req_item_t it;
        it.req_type    = 3'($urandom);
        it.level       = 16'($urandom);
        it.start_level = 16'($urandom);
        it.fade_len    = 24'($urandom);
        it.flick_limit = 24'($urandom);
        return it;
    endfunction

    // mostly near the legal range, sometimes anywhere in 16 bits
    function automatic logic signed [15:0] pick_level();
        if ($urandom_range(0, 4) == 0)
        begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(0, 320)) - 30);
    endfunction

    task automatic add_row(input logic [2:0] code, input int lv, input int st, input int dur,
                           input int ivl, input int reps, input bit fixed, input int want_lvl,
                           input logic [1:0] want_mode);
        row_t r;
        r.item.req_type    = code;
        r.item.level       = 16'(lv);
        r.item.start_level = 16'(st);
        r.item.fade_len    = 24'(dur);
        r.item.flick_limit = 24'(ivl);
        r.reps             = reps;
        r.fixed            = fixed;
        r.want.cur_level   = 8'(want_lvl);
        r.want.mode        = want_mode;
        plan.push_back(r);
    endtask

    task automatic send(input lffe_pkg::req_item_t it, input bit fixed,
                        input lffe_pkg::rsp_item_t want);
        int                  gap;
        lffe_pkg::rsp_item_t pred;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        pred = lamp_step(it);
        level_due.push_back(fixed ? want : pred);
        case (it.req_type)
            lffe_pkg::REQ_TICK:                               tick_count++;
            lffe_pkg::REQ_FADE_CUR, lffe_pkg::REQ_FADE_START: fade_count++;
            lffe_pkg::REQ_FLICKER:                            flick_count++;
            default:                                          ;
        endcase
        if (it.req_type <= lffe_pkg::REQ_FLICKER)
        begin
            sent_count++;
        end
    endtask

    task automatic send_pred(input lffe_pkg::req_item_t it);
        send(it, 1'b0, '0);
    endtask

    task automatic send_ticks(input int n);
        lffe_pkg::req_item_t it;
        repeat (n)
        begin
            it = noise_item();
            if ($urandom_range(0, 9) == 0)
            begin
                it.req_type = lffe_pkg::REQ_SET;
                it.level    = pick_level();
            end
            else
            begin
                it.req_type = lffe_pkg::REQ_TICK;
            end
            send_pred(it);
        end
    endtask

    // hold off new items until every result is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (level_due.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // result side
    initial
    begin
        int                  n;
        lffe_pkg::rsp_item_t exp_r;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
            begin
                @(posedge clk);
            end
            if (level_due.size() == 0)
            begin
                $display("%0t: unexpected item: level %0d mode %0d", $time,
                         rsp.cur_level, rsp.mode);
                err_count++;
            end
            else
            begin
                exp_r = level_due.pop_front();
                checked_count++;
                if (rsp.cur_level !== exp_r.cur_level)
                begin
                    $display("%0t: cur_level expected %0d actual %0d", $time,
                             exp_r.cur_level, rsp.cur_level);
                    err_count++;
                end
                if (rsp.mode !== exp_r.mode)
                begin
                    $display("%0t: mode expected %0d actual %0d", $time,
                             exp_r.mode, rsp.mode);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        lffe_pkg::req_item_t it;
        int                  pick;
        int                  n;
        int                  waited;
        bit                  mid_drain;

        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        calm      = 1'b0;
        mid_drain = 1'b0;
        err_count = 0;

        lvl_q     = DEFL;
        mode_q    = lffe_pkg::MODE_CONST;
        elapsed_q = 0;
        len_q     = 0;
        rstart_q  = 0;
        rtarget_q = 0;
        bound_q   = 0;
        lfsr_q    = lffe_pkg::LFSR_SEED;

        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 1, 1, DEFL, lffe_pkg::MODE_CONST);
        add_row(REQ_RSVD5, 0, 0, 0, 0, 1, 1, DEFL, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_SET, 32767, 0, 0, 0, 1, 1, MAXL, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_SET, -32768, 0, 0, 0, 1, 1, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_SET, 100, 0, 0, 0, 1, 1, 100, lffe_pkg::MODE_CONST);
        add_row(REQ_RSVD7, -1, 32767, 'hFFFFFF, 'hFFFFFF, 1, 1, 100, lffe_pkg::MODE_CONST);
        // zero duration: the next tick lands on the target
        add_row(lffe_pkg::REQ_FADE_CUR, 32767, 0, 0, 0, 1, 1, 100, lffe_pkg::MODE_FADE);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 1, 1, MAXL, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_FADE_START, 200, -32768, 4, 0, 1, 1, MAXL, lffe_pkg::MODE_FADE);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 1, 0, 0, lffe_pkg::MODE_CONST);
        // set during a fade keeps the fade going
        add_row(lffe_pkg::REQ_SET, 7, 0, 0, 0, 1, 1, 7, lffe_pkg::MODE_FADE);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 2, 0, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 1, 1, 200, lffe_pkg::MODE_CONST);
        // falling ramp, truncation toward zero
        add_row(lffe_pkg::REQ_FADE_START, -5, 32767, 3, 0, 1, 1, 200, lffe_pkg::MODE_FADE);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 3, 0, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_SET, 120, 0, 0, 0, 1, 1, 120, lffe_pkg::MODE_CONST);
        // interval below the minimum ramp length
        add_row(lffe_pkg::REQ_FLICKER, 0, 0, 0, 5, 1, 1, 120, lffe_pkg::MODE_FLICKER);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 22, 0, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_FLICKER, 0, 0, 0, 'hFFFFFF, 1, 0, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 5, 0, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_SET, 60, 0, 0, 0, 1, 1, 60, lffe_pkg::MODE_FLICKER);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 3, 0, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_FADE_CUR, 255, 0, 'hFFFFFF, 0, 1, 0, 0, lffe_pkg::MODE_CONST);
        add_row(lffe_pkg::REQ_TICK, 0, 0, 0, 0, 4, 0, 0, lffe_pkg::MODE_CONST);
        add_row(REQ_RSVD6, 0, 0, 0, 0, 1, 0, 0, lffe_pkg::MODE_CONST);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            repeat (plan[i].reps)
            begin
                send(plan[i].item, plan[i].fixed, plan[i].want);
            end
        end
        drain();

        while (sent_count < ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                calm = ~calm;
            end
            if (!mid_drain && sent_count > ITEMS / 2)
            begin
                mid_drain = 1'b1;
                drain();
            end
            pick = $urandom_range(0, 99);
            it   = noise_item();
            if (pick < 30)
            begin
                it.req_type = ($urandom_range(0, 1) == 0) ? lffe_pkg::REQ_FADE_CUR
                                                          : lffe_pkg::REQ_FADE_START;
                it.level       = pick_level();
                it.start_level = pick_level();
                if ($urandom_range(0, 7) != 0)
                begin
                    it.fade_len = 24'($urandom_range(0, 20));
                    n = it.fade_len + $urandom_range(0, 3);
                end
                else
                begin
                    n = $urandom_range(1, 8);
                end
                send_pred(it);
                send_ticks(n);
            end
            else if (pick < 55)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    it.req_type = lffe_pkg::REQ_SET;
                    it.level    = pick_level();
                    send_pred(it);
                    it = noise_item();
                end
                it.req_type = lffe_pkg::REQ_FLICKER;
                if ($urandom_range(0, 7) != 0)
                begin
                    it.flick_limit = 24'($urandom_range(0, 40));
                end
                send_pred(it);
                send_ticks($urandom_range(10, 40));
            end
            else if (pick < 75)
            begin
                it.req_type = lffe_pkg::REQ_SET;
                it.level    = pick_level();
                send_pred(it);
            end
            else if (pick < 90)
            begin
                send_ticks($urandom_range(1, 5));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       it.req_type = REQ_RSVD5;
                    1:       it.req_type = REQ_RSVD6;
                    default: it.req_type = REQ_RSVD7;
                endcase
                send_pred(it);
            end
        end

        req_valid <= 1'b0;
        waited = 0;
        while (level_due.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (level_due.size() > 0)
        begin
            $display("%0t: %0d items never came back", $time, level_due.size());
            err_count++;
        end
        repeat (200) @(posedge clk);

        $display("run: %0d items (%0d ticks, %0d fades, %0d flickers), %0d results compared",
                 sent_count, tick_count, fade_count, flick_count, checked_count);
        $display("run: %0d flicker ramp restarts, %0d mismatches", restart_count, err_count);
        if (err_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
